[hdl/gfp_pkg.sv]
// Shared types and constants for the grid first-fit placer.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package gfp_pkg;

  localparam int unsigned GFP_COLUMNS = 8;
  localparam int unsigned GFP_ROWS    = 15;

  localparam int unsigned DIM_W   = 4;
  localparam int unsigned SLOT_W  = 7;
  localparam int unsigned COUNT_W = 7;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

  typedef enum logic {
    REQ_PLACE = 1'b0,
    REQ_CLEAR = 1'b1
  } gfp_req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MARK
  } gfp_state_e;

  typedef struct packed {
    gfp_req_e           req_type;
    logic [DIM_W-1:0]   rect_width;
    logic [DIM_W-1:0]   rect_height;
  } gfp_req_t;

  typedef struct packed {
    logic               placed;
    logic [SLOT_W-1:0]  slot_index;
    logic [COUNT_W-1:0] placed_count;
  } gfp_rsp_t;

  // row store controls
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wipe;
  } store_ctl_t;

  // run lane controls
  typedef struct packed {
    logic clear;
    logic step;
  } lane_ctl_t;

endpackage

[hdl/gfp_row_store.sv]
// Occupancy row memory: one write port, one registered read port.
// Per-row valid bits make unwritten or wiped rows read as free. Uses gfp_pkg.
`timescale 1ns / 1ps

module gfp_row_store #(
  parameter int unsigned GRID_COLUMNS = gfp_pkg::GFP_COLUMNS,
  parameter int unsigned GRID_ROWS    = gfp_pkg::GFP_ROWS,
  localparam int unsigned RW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  gfp_pkg::store_ctl_t      ctl_i,
  input  logic [RW-1:0]            rd_addr_i,
  input  logic [RW-1:0]            wr_addr_i,
  input  logic [GRID_COLUMNS-1:0]  wr_data_i,
  output logic [GRID_COLUMNS-1:0]  rd_data_o
);
  import gfp_pkg::*;

  logic [GRID_COLUMNS-1:0] mem_q [GRID_ROWS];
  logic [GRID_ROWS-1:0]    vld_q;
  logic [GRID_COLUMNS-1:0] rd_data_q;
  logic                    rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctl_i.wipe) begin
        vld_q <= '0;
      end else if (ctl_i.wr_en) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

[hdl/gfp_run_lanes.sv]
// One lane per column: counts consecutive rows in which the rectangle's span
// starting at that column is free, and flags the leftmost lane that reaches
// the height. Uses gfp_pkg.
`timescale 1ns / 1ps

module gfp_run_lanes #(
  parameter int unsigned GRID_COLUMNS = gfp_pkg::GFP_COLUMNS,
  localparam int unsigned XW = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gfp_pkg::lane_ctl_t            ctl_i,
  input  logic [GRID_COLUMNS-1:0]       row_i,
  input  logic [gfp_pkg::DIM_W-1:0]     width_i,
  input  logic [gfp_pkg::DIM_W-1:0]     height_i,
  output logic                          hit_o,
  output logic [XW-1:0]                 hit_col_o
);
  import gfp_pkg::*;

  logic [DIM_W-1:0]        run_q [GRID_COLUMNS];
  logic [DIM_W-1:0]        run_d [GRID_COLUMNS];
  logic [GRID_COLUMNS-1:0] wmask;
  logic [GRID_COLUMNS-1:0] fits;
  logic [GRID_COLUMNS-1:0] hit_v;

  always_comb begin
    for (int i = 0; i < GRID_COLUMNS; i++) begin
      wmask[i] = (6'(i) < {2'b00, width_i});
    end
  end

  always_comb begin
    for (int x = 0; x < GRID_COLUMNS; x++) begin
      fits[x]  = ((6'(x) + {2'b00, width_i}) <= 6'(GRID_COLUMNS)) &&
                 ((row_i & (wmask << x)) == '0);
      hit_v[x] = fits[x] && (({1'b0, run_q[x]} + 5'd1) >= {1'b0, height_i});
      if (!fits[x]) begin
        run_d[x] = '0;
      end else if (run_q[x] == {DIM_W{1'b1}}) begin
        run_d[x] = run_q[x];
      end else begin
        run_d[x] = run_q[x] + 4'd1;
      end
    end
  end

  // leftmost hit wins
  always_comb begin
    hit_col_o = '0;
    for (int x = GRID_COLUMNS - 1; x >= 0; x--) begin
      if (hit_v[x]) begin
        hit_col_o = XW'(x);
      end
    end
  end

  assign hit_o = ctl_i.step && (hit_v != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int x = 0; x < GRID_COLUMNS; x++) begin
        run_q[x] <= '0;
      end
    end else if (ctl_i.clear) begin
      for (int x = 0; x < GRID_COLUMNS; x++) begin
        run_q[x] <= '0;
      end
    end else if (ctl_i.step) begin
      for (int x = 0; x < GRID_COLUMNS; x++) begin
        run_q[x] <= run_d[x];
      end
    end
  end

endmodule

[hdl/grid_first_fit_placer.sv]
// Grid first-fit placer: clear requests and rejected sizes answer in the cycle
// after acceptance. A place request scans up to GRID_ROWS rows (one memory
// row read per cycle) and, on a fit, marks rect_height rows (one row read-
// modify-write per cycle); one item at a time, busy high meanwhile. The
// receiver cannot stall; the result strobe is done_o. Reset empties the map
// at once through per-row valid bits and zeroes the count.
`timescale 1ns / 1ps

module grid_first_fit_placer #(
  parameter int unsigned GRID_COLUMNS = gfp_pkg::GFP_COLUMNS,
  parameter int unsigned GRID_ROWS    = gfp_pkg::GFP_ROWS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  gfp_pkg::gfp_req_t req_i,
  output logic              done_o,
  output gfp_pkg::gfp_rsp_t rsp_o
);
  import gfp_pkg::*;

  localparam int unsigned XW = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;
  localparam int unsigned RW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam logic [RW-1:0] LAST_ROW = RW'(GRID_ROWS - 1);

  gfp_state_e state_q, state_d;

  logic [DIM_W-1:0]        w_q, w_d;
  logic [DIM_W-1:0]        h_q, h_d;
  logic [RW-1:0]           row_q, row_d;
  logic [DIM_W-1:0]        left_q, left_d;
  logic [XW-1:0]           x_q, x_d;
  logic [RW-1:0]           y_q, y_d;
  logic [GRID_COLUMNS-1:0] mask_q, mask_d;
  logic [COUNT_W-1:0]      count_q, count_d;
  gfp_rsp_t                rsp_q, rsp_d;
  logic                    done_q, done_d;

  logic                    accept;
  logic                    is_clear;
  logic                    bad_size;
  store_ctl_t              st_ctl;
  lane_ctl_t               ln_ctl;
  logic [RW-1:0]           rd_addr;
  logic [GRID_COLUMNS-1:0] rd_row;
  logic                    hit;
  logic [XW-1:0]           hit_col;
  logic [6:0]              top_w;
  logic [RW-1:0]           top_y;
  logic [GRID_COLUMNS-1:0] wmask;
  logic [COUNT_W-1:0]      count_inc;
  logic [11:0]             slot_w;

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign is_clear = (req_i.req_type == REQ_CLEAR);
  assign bad_size = (req_i.rect_width == '0) || (req_i.rect_height == '0) ||
                    ({2'b00, req_i.rect_width} > 6'(GRID_COLUMNS)) ||
                    ({3'b000, req_i.rect_height} > 7'(GRID_ROWS));

  // top row of a window that completes at the current row
  assign top_w = 7'(row_q) + 7'd1 - {3'b000, h_q};
  assign top_y = top_w[RW-1:0];

  always_comb begin
    for (int i = 0; i < GRID_COLUMNS; i++) begin
      wmask[i] = (6'(i) < {2'b00, w_q});
    end
  end

  assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + 7'd1;
  assign slot_w    = 12'(x_q) + 12'(y_q) * 12'(GRID_COLUMNS);

  gfp_row_store #(
    .GRID_COLUMNS(GRID_COLUMNS),
    .GRID_ROWS   (GRID_ROWS)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (st_ctl),
    .rd_addr_i(rd_addr),
    .wr_addr_i(row_q),
    .wr_data_i(rd_row | mask_q),
    .rd_data_o(rd_row)
  );

  gfp_run_lanes #(
    .GRID_COLUMNS(GRID_COLUMNS)
  ) u_lanes (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ln_ctl),
    .row_i    (rd_row),
    .width_i  (w_q),
    .height_i (h_q),
    .hit_o    (hit),
    .hit_col_o(hit_col)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && !is_clear && !bad_size) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_d = ST_MARK;
        end else if (row_q == LAST_ROW) begin
          state_d = ST_IDLE;
        end
      end
      ST_MARK: begin
        if (left_q == 4'd1) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // memory and lane controls
  always_comb begin
    st_ctl  = '0;
    ln_ctl  = '0;
    rd_addr = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept && is_clear) begin
          st_ctl.wipe = 1'b1;
        end else if (accept && !bad_size) begin
          st_ctl.rd_en = 1'b1;
          ln_ctl.clear = 1'b1;
        end
      end
      ST_SCAN: begin
        ln_ctl.step = 1'b1;
        if (hit) begin
          st_ctl.rd_en = 1'b1;
          rd_addr      = top_y;
        end else if (row_q != LAST_ROW) begin
          st_ctl.rd_en = 1'b1;
          rd_addr      = row_q + 1'b1;
        end
      end
      ST_MARK: begin
        // write this row while the next one is read
        st_ctl.wr_en = 1'b1;
        if (left_q != 4'd1) begin
          st_ctl.rd_en = 1'b1;
          rd_addr      = row_q + 1'b1;
        end
      end
      default: begin
        st_ctl = '0;
      end
    endcase
  end

  // datapath and result
  always_comb begin
    w_d     = w_q;
    h_d     = h_q;
    row_d   = row_q;
    left_d  = left_q;
    x_d     = x_q;
    y_d     = y_q;
    mask_d  = mask_q;
    count_d = count_q;
    rsp_d   = rsp_q;
    done_d  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          w_d   = req_i.rect_width;
          h_d   = req_i.rect_height;
          row_d = '0;
          if (is_clear) begin
            count_d = '0;
            done_d  = 1'b1;
            rsp_d   = '0;
          end else if (bad_size) begin
            done_d             = 1'b1;
            rsp_d.placed       = 1'b0;
            rsp_d.slot_index   = '0;
            rsp_d.placed_count = count_q;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          row_d  = top_y;
          y_d    = top_y;
          x_d    = hit_col;
          left_d = h_q;
          mask_d = wmask << hit_col;
        end else if (row_q == LAST_ROW) begin
          done_d             = 1'b1;
          rsp_d.placed       = 1'b0;
          rsp_d.slot_index   = '0;
          rsp_d.placed_count = count_q;
        end else begin
          row_d = row_q + 1'b1;
        end
      end
      ST_MARK: begin
        row_d  = row_q + 1'b1;
        left_d = left_q - 4'd1;
        if (left_q == 4'd1) begin
          count_d            = count_inc;
          done_d             = 1'b1;
          rsp_d.placed       = 1'b1;
          rsp_d.slot_index   = slot_w[SLOT_W-1:0];
          rsp_d.placed_count = count_inc;
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q    <= w_d;
    h_q    <= h_d;
    row_q  <= row_d;
    left_q <= left_d;
    x_q    <= x_d;
    y_q    <= y_d;
    mask_q <= mask_d;
    rsp_q  <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  a_no_rw_same_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_ctl.wr_en && st_ctl.rd_en) |-> (rd_addr != row_q))
    else $error("row read and written in the same cycle");

  a_clear_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_clear) |=> (done_o && !rsp_o.placed && rsp_o.placed_count == '0))
    else $error("clear request not answered with an empty result");

  a_busy_ends_with_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("place request finished without a result");

  a_placed_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.placed) |-> (rsp_o.placed_count != '0))
    else $error("placement reported with zero count");
`endif

endmodule

[dv/grid_first_fit_placer_test.sv]
// Self-checking testbench for the grid first-fit placer: directed and random
// place and clear items, checked against an in-bench occupancy-grid predictor.
// Depends on gfp_pkg and grid_first_fit_placer from hdl.
`timescale 1ns / 1ps

module grid_first_fit_placer_test;
  import gfp_pkg::*;

  localparam int RANDOM_ITEMS = 800;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    gfp_req_t req;
    bit       wait_idle;
  } pending_item_t;

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  gfp_req_t req_i  = '0;
  logic     busy;
  logic     done_o;
  gfp_rsp_t rsp_o;

  pending_item_t pending_items[$];
  gfp_rsp_t      expected_rsp[$];
  int            open_items = 0;
  int            launched   = 0;
  int            mismatches = 0;
  int            cycles     = 0;

  // predictor state
  logic [GFP_COLUMNS-1:0] occ_rows [GFP_ROWS];
  logic [COUNT_W-1:0]     rect_total = '0;

  grid_first_fit_placer DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  task automatic report(input string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic queue_item(input gfp_req_e kind, input int w, input int h, input bit hold);
    pending_item_t it;
    it.req.req_type    = kind;
    it.req.rect_width  = DIM_W'(w);
    it.req.rect_height = DIM_W'(h);
    it.wait_idle       = hold;
    pending_items = {pending_items, it};
  endtask

  // First fit: scan free top-left cells row by row, left to right.
  function automatic gfp_rsp_t grid_predict(input gfp_req_t r);
    gfp_rsp_t          rsp;
    logic [31:0]       wide;
    logic [GFP_COLUMNS-1:0] span;
    int                w;
    int                h;
    bit                clash;
    rsp = '0;
    if (r.req_type == REQ_CLEAR) begin
      for (int y = 0; y < GFP_ROWS; y++) occ_rows[y] = '0;
      rect_total = '0;
      return rsp;
    end
    w = int'(r.rect_width);
    h = int'(r.rect_height);
    if (w != 0 && h != 0) begin
      for (int y = 0; y < GFP_ROWS; y++) begin
        for (int x = 0; x < GFP_COLUMNS; x++) begin
          if (occ_rows[y][x] || x + w > GFP_COLUMNS || y + h > GFP_ROWS) continue;
          wide  = ((32'd1 << w) - 32'd1) << x;
          span  = wide[GFP_COLUMNS-1:0];
          clash = 1'b0;
          for (int k = 0; k < h; k++) if ((occ_rows[y+k] & span) != '0) clash = 1'b1;
          if (clash) continue;
          for (int k = 0; k < h; k++) occ_rows[y+k] |= span;
          if (rect_total < COUNT_MAX) rect_total++;
          rsp.placed       = 1'b1;
          rsp.slot_index   = SLOT_W'(x + y * GFP_COLUMNS);
          rsp.placed_count = rect_total;
          return rsp;
        end
      end
    end
    rsp.placed_count = rect_total;
    return rsp;
  endfunction

  // Driver: hold start until the item is taken, then launch the next or idle.
  always @(posedge clk_i) begin : drive
    bit            took;
    int            gap_pct;
    pending_item_t head;
    if (rst_ni) begin
      took    = start && !busy;
      gap_pct = (launched < 280) ? 38 : (launched < 560) ? 73 : 0;
      if (!start || took) begin
        if (pending_items.size() != 0
            && !(pending_items[0].wait_idle && (took || open_items != 0))
            && $urandom_range(99) >= gap_pct) begin
          head = pending_items.pop_front();
          req_i <= head.req;
          start <= 1'b1;
          launched++;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: check results first, then record the item taken at this edge.
  always @(posedge clk_i) begin : observe
    gfp_rsp_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_rsp.size() == 0) begin
          report($sformatf("result with no item outstanding: %p", rsp_o));
        end else begin
          want = expected_rsp.pop_front();
          if (rsp_o.placed !== want.placed)
            report($sformatf("placed %b, want %b", rsp_o.placed, want.placed));
          if (rsp_o.slot_index !== want.slot_index)
            report($sformatf("slot_index %0d, want %0d", rsp_o.slot_index, want.slot_index));
          if (rsp_o.placed_count !== want.placed_count)
            report($sformatf("placed_count %0d, want %0d",
                             rsp_o.placed_count, want.placed_count));
        end
      end
      if (start && !busy) expected_rsp = {expected_rsp, grid_predict(req_i)};
      open_items <= open_items + int'(start && !busy) - int'(done_o);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    int n;
    int pick;
    int burst;
    for (int y = 0; y < GFP_ROWS; y++) occ_rows[y] = '0;

    // directed part
    queue_item(REQ_PLACE, 1, 1, 1'b0);
    queue_item(REQ_PLACE, 8, 1, 1'b0);
    queue_item(REQ_PLACE, 1, 15, 1'b0);
    queue_item(REQ_PLACE, 0, 3, 1'b0);
    queue_item(REQ_PLACE, 3, 0, 1'b0);
    queue_item(REQ_PLACE, 15, 15, 1'b0);
    queue_item(REQ_PLACE, 9, 1, 1'b0);
    queue_item(REQ_CLEAR, 15, 15, 1'b0);
    queue_item(REQ_PLACE, 8, 15, 1'b0);
    queue_item(REQ_PLACE, 1, 1, 1'b0);
    queue_item(REQ_CLEAR, 0, 0, 1'b0);
    queue_item(REQ_PLACE, 1, 15, 1'b0);
    queue_item(REQ_PLACE, 7, 15, 1'b0);
    queue_item(REQ_PLACE, 1, 1, 1'b0);
    queue_item(REQ_CLEAR, 5, 10, 1'b0);
    queue_item(REQ_PLACE, 3, 2, 1'b0);
    queue_item(REQ_PLACE, 2, 5, 1'b0);
    queue_item(REQ_PLACE, 5, 4, 1'b0);
    queue_item(REQ_PLACE, 8, 13, 1'b0);
    queue_item(REQ_PLACE, 1, 1, 1'b0);
    queue_item(REQ_PLACE, 2, 2, 1'b0);
    queue_item(REQ_PLACE, 0, 0, 1'b0);
    queue_item(REQ_CLEAR, 0, 15, 1'b0);

    // random part: mostly small rectangles that pack the grid, with clears,
    // runs of unit cells that fill free cells, and odd or oversized sizes
    n = 0;
    while (n < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        queue_item(REQ_CLEAR, $urandom_range(15), $urandom_range(15), n % 270 == 150);
        n++;
      end else if (pick < 6) begin
        burst = $urandom_range(60, 20);
        repeat (burst) begin
          queue_item(REQ_PLACE, 1, 1, n % 270 == 150);
          n++;
        end
      end else if (pick < 72) begin
        queue_item(REQ_PLACE, $urandom_range(4, 1), $urandom_range(4, 1), n % 270 == 150);
        n++;
      end else if (pick < 90) begin
        queue_item(REQ_PLACE, $urandom_range(8, 1), $urandom_range(15, 1), n % 270 == 150);
        n++;
      end else begin
        queue_item(REQ_PLACE, $urandom_range(15), $urandom_range(15), n % 270 == 150);
        n++;
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i); while (pending_items.size() != 0 || start || open_items != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (expected_rsp.size() != 0)
      report($sformatf("%0d expected results never arrived", expected_rsp.size()));
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[grid_first_fit_placer.f]
hdl/gfp_pkg.sv
hdl/gfp_row_store.sv
hdl/gfp_run_lanes.sv
hdl/grid_first_fit_placer.sv
dv/grid_first_fit_placer_test.sv
